@@ hdl/six_axis_force_torque_conversion_macros.svh @@
// Assertion helpers for the force/torque conversion block.
`ifndef SIX_AXIS_FORCE_TORQUE_CONVERSION_MACROS_SVH
`define SIX_AXIS_FORCE_TORQUE_CONVERSION_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define FTC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define FTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FTC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/ftc_pkg.sv @@
package ftc_pkg;

  localparam int AXES          = 6;
  localparam int GAUGE_COUNT   = 6;
  localparam int FRACTION_BITS = 12;

  localparam int OP_W       = 2;
  localparam int CODE_W     = 16;
  localparam int DIFF_W     = CODE_W + 1;
  localparam int COEF_W     = 20;
  localparam int COEF_IDX_W = 6;
  localparam int COEF_DEPTH = AXES * GAUGE_COUNT;
  localparam int PROD_W     = DIFF_W + COEF_W;
  localparam int SUM_W      = PROD_W + $clog2(GAUGE_COUNT);
  localparam int OUT_W      = 32;

  typedef enum logic [OP_W-1:0] {
    OP_MEASURE = 2'd0,
    OP_CAPTURE = 2'd1,
    OP_WRITE   = 2'd2
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [CODE_W-1:0] gauge_a;
    logic signed [CODE_W-1:0] gauge_b;
    logic signed [CODE_W-1:0] gauge_c;
    logic signed [CODE_W-1:0] gauge_d;
    logic signed [CODE_W-1:0] gauge_e;
    logic signed [CODE_W-1:0] gauge_f;
    logic [COEF_IDX_W-1:0]    coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
    logic signed [OUT_W-1:0] torque_x;
    logic signed [OUT_W-1:0] torque_y;
    logic signed [OUT_W-1:0] torque_z;
  } out_item_t;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  // Floor shift by the fraction width, then clamp to the output range.
  function automatic logic signed [OUT_W-1:0] shift_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] sh;
    sh = s >>> FRACTION_BITS;
    if (sh > SAT_HI) begin
      return SAT_HI[OUT_W-1:0];
    end else if (sh < SAT_LO) begin
      return SAT_LO[OUT_W-1:0];
    end
    return sh[OUT_W-1:0];
  endfunction

endpackage

@@ hdl/six_axis_force_torque_conversion.sv @@
// Channel | Ports                          | Payload     | Transfer when
// --------+--------------------------------+-------------+--------------------
// input   | in_valid, in_stall, in_data    | in_item_t   | in_valid & !in_stall
// result  | out_valid, out_stall, out_data | out_item_t  | out_valid & !out_stall
//
// One item per cycle sustained while the result is not stalled; a measure reaches
// out_valid via bias subtract into stage A, then products, row sums, shift/clamp.
// Throughput is set by the fully parallel multiplier array: one stage each.
// Reset (rst_n low, synchronous) clears all stage valids, bias and matrix.
// A stalled result holds; stages behind it keep filling until each is full,
// so in_stall rises only once every stage holds an item.
module six_axis_force_torque_conversion
  import ftc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

`include "six_axis_force_torque_conversion_macros.svh"

  // ---------------------------------------------------------------------------
  // Architectural state: bias codes and calibration matrix.
  // Every matrix entry feeds its own multiplier, so plain flops suffice.
  // ---------------------------------------------------------------------------
  logic signed [CODE_W-1:0] bias_r [GAUGE_COUNT];
  logic signed [COEF_W-1:0] coef_r [COEF_DEPTH];

  // Pipeline registers
  logic                     a_valid_r;
  logic [OP_W-1:0]          a_op_r;
  logic [COEF_IDX_W-1:0]    a_idx_r;
  logic signed [COEF_W-1:0] a_coef_r;
  logic signed [DIFF_W-1:0] a_diff_r [GAUGE_COUNT];

  logic                     b_valid_r;
  logic signed [PROD_W-1:0] b_prod_r [AXES][GAUGE_COUNT];
  logic signed [PROD_W-1:0] b_prod_nxt [AXES][GAUGE_COUNT];

  logic                     c_valid_r;
  logic signed [SUM_W-1:0]  c_sum_r [AXES];
  logic signed [SUM_W-1:0]  c_sum_nxt [AXES];

  logic                     out_valid_r;
  out_item_t                out_data_r;
  out_item_t                out_data_nxt;

  // Control
  logic rdy_o, rdy_c, rdy_b, rdy_a;
  logic in_xfer;
  logic a_enter, b_enter;
  logic bias_we, coef_we;

  logic signed [CODE_W-1:0] codes [GAUGE_COUNT];
  logic signed [DIFF_W-1:0] a_diff_nxt [GAUGE_COUNT];

  assign codes[0] = in_data.gauge_a;
  assign codes[1] = in_data.gauge_b;
  assign codes[2] = in_data.gauge_c;
  assign codes[3] = in_data.gauge_d;
  assign codes[4] = in_data.gauge_e;
  assign codes[5] = in_data.gauge_f;

  // Each stage moves when empty or when the one ahead moves.
  assign rdy_o   = !out_valid_r || !out_stall;
  assign rdy_c   = !c_valid_r || rdy_o;
  assign rdy_b   = !b_valid_r || rdy_c;
  assign rdy_a   = !a_valid_r || rdy_b;
  assign in_stall = !rdy_a;
  assign in_xfer  = in_valid && rdy_a;

  // Bias capture completes at transfer; only measures and writes go on.
  assign bias_we = in_xfer && (in_data.operation == OP_CAPTURE);
  assign a_enter = in_xfer &&
                   ((in_data.operation == OP_MEASURE) || (in_data.operation == OP_WRITE));

  // Coefficient write retires as it leaves stage A, after every earlier
  // measure already has its products latched.
  assign coef_we = a_valid_r && rdy_b && (a_op_r == OP_WRITE) &&
                   (a_idx_r < COEF_IDX_W'(COEF_DEPTH));
  assign b_enter = a_valid_r && (a_op_r == OP_MEASURE);

  // Stage A: subtract bias (old bias; a capture never yields a result).
  always_comb begin
    for (int g = 0; g < GAUGE_COUNT; g++) begin
      a_diff_nxt[g] = DIFF_W'(codes[g]) - DIFF_W'(bias_r[g]);
    end
  end

  // Stage B: 36 products in parallel.
  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      for (int g = 0; g < GAUGE_COUNT; g++) begin
        b_prod_nxt[r][g] = a_diff_r[g] * coef_r[r*GAUGE_COUNT + g];
      end
    end
  end

  // Stage C: row sums, exact.
  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      c_sum_nxt[r] = '0;
      for (int g = 0; g < GAUGE_COUNT; g++) begin
        c_sum_nxt[r] = c_sum_nxt[r] + SUM_W'(b_prod_r[r][g]);
      end
    end
  end

  // Output: floor shift and clamp.
  always_comb begin
    out_data_nxt.force_x  = shift_sat(c_sum_r[0]);
    out_data_nxt.force_y  = shift_sat(c_sum_r[1]);
    out_data_nxt.force_z  = shift_sat(c_sum_r[2]);
    out_data_nxt.torque_x = shift_sat(c_sum_r[3]);
    out_data_nxt.torque_y = shift_sat(c_sum_r[4]);
    out_data_nxt.torque_z = shift_sat(c_sum_r[5]);
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int g = 0; g < GAUGE_COUNT; g++) begin
        bias_r[g] <= '0;
      end
      for (int i = 0; i < COEF_DEPTH; i++) begin
        coef_r[i] <= '0;
      end
    end else begin
      if (rdy_a) begin
        a_valid_r <= a_enter;
      end
      if (rdy_b) begin
        b_valid_r <= b_enter;
      end
      if (rdy_c) begin
        c_valid_r <= b_valid_r;
      end
      if (rdy_o) begin
        out_valid_r <= c_valid_r;
      end
      if (bias_we) begin
        for (int g = 0; g < GAUGE_COUNT; g++) begin
          bias_r[g] <= codes[g];
        end
      end
      if (coef_we) begin
        coef_r[a_idx_r] <= a_coef_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_op_r   <= in_data.operation;
      a_idx_r  <= in_data.coef_index;
      a_coef_r <= in_data.coef_value;
      for (int g = 0; g < GAUGE_COUNT; g++) begin
        a_diff_r[g] <= a_diff_nxt[g];
      end
    end
    if (rdy_b) begin
      for (int r = 0; r < AXES; r++) begin
        for (int g = 0; g < GAUGE_COUNT; g++) begin
          b_prod_r[r][g] <= b_prod_nxt[r][g];
        end
      end
    end
    if (rdy_c) begin
      for (int r = 0; r < AXES; r++) begin
        c_sum_r[r] <= c_sum_nxt[r];
      end
    end
    if (rdy_o) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Assertions
  `FTC_ASSERT_IMPLIES(a_empty_accepts, clk, rst_n, !a_valid_r, !in_stall)
  `FTC_ASSERT_NEXT(b_needs_a, clk, rst_n, !a_valid_r && !b_valid_r, !b_valid_r)
  `FTC_ASSERT_NEXT(out_needs_c, clk, rst_n, !c_valid_r && !out_valid_r, !out_valid_r)
  `FTC_ASSERT_NEXT(c_holds_on_stall, clk, rst_n, c_valid_r && out_valid_r && out_stall, c_valid_r && $stable(c_sum_r[0]))

endmodule
